// ----- design/b64e_pkg.sv -----
// shared types, constants and the alphabet function of the base64 stream encoder
package b64e_pkg;

	localparam logic [7:0] PadChar   = 8'h3D;
	localparam logic [7:0] UpperBase = 8'h41;
	localparam logic [7:0] LowerBase = 8'h47;
	localparam logic [7:0] DigitBase = 8'hFC;
	localparam logic [7:0] PlusChar  = 8'h2B;
	localparam logic [7:0] SlashChar = 8'h2F;

	typedef struct packed {
		logic [23:0] bits;
		logic [1:0]  total;
		logic        last;
	} group_t;

	typedef struct packed {
		logic   valid;
		group_t grp;
	} push_t;

	typedef struct packed {
		logic   valid;
		logic   full;
		group_t grp;
	} head_t;

	function automatic logic [7:0] sextet_char(input logic [5:0] v);
		logic [7:0] r;
		if (v < 6'd26) begin
			r = UpperBase + {2'b00, v};
		end else if (v < 6'd52) begin
			r = LowerBase + {2'b00, v};
		end else if (v < 6'd62) begin
			r = DigitBase + {2'b00, v};
		end else if (v == 6'd62) begin
			r = PlusChar;
		end else begin
			r = SlashChar;
		end
		return r;
	endfunction

endpackage

// ----- design/b64e_if.sv -----
// handshake interfaces for raw bytes in and encoded characters out
interface b64e_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_message;
	modport source (output valid, output data_byte, output end_of_message, input ready);
	modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b64e_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last_char;
	modport source (output valid, output out_char, output last_char, input ready);
	modport sink (input valid, input out_char, input last_char, output ready);
endinterface

// ----- design/base64_stream_encoder.sv -----
// top level of the base64 stream encoder
//
// raw channel: one message byte per transfer, with end_of_message on the final
// byte of a message. enc channel: one ASCII character per transfer, with
// last_char on the final character of the encoded message.
// every three bytes, or the final byte of a message, close a group that is
// encoded into four characters; a short final group is zero filled and ends
// in one or two '=' pads.
// the first character of a group is offered once the group has passed
// through the queue, the group register and the output register; the other
// three follow one per cycle while enc.ready is high. the enc channel moves
// one character per cycle, but holds its character while enc.ready is low.
// a two-group queue sits between the byte collector and the character
// stage; raw.ready drops only while that queue is full, so bytes keep
// flowing while enc stalls until two groups are waiting.
// reset clears the pending byte count, the queue and the output register;
// nothing is offered on enc until a group is complete.
module base64_stream_encoder (
	input  logic        clk,
	input  logic        arst_n,
	b64e_in_if.sink     raw,
	b64e_out_if.source  enc
);

	b64e_pkg::push_t push;
	b64e_pkg::head_t head;
	logic            pop;

	b64e_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.raw    (raw),
		.head   (head),
		.push   (push)
	);

	b64e_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head)
	);

	b64e_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.enc    (enc)
	);

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !head.full)
		else $error("group pushed into a full queue");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("group popped from an empty queue");

	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		head.full |-> !raw.ready)
		else $error("byte taken while the queue is full");

	a_pop_resets_stage: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> !(enc.valid && enc.last_char && $past(enc.valid && !enc.ready)
			&& !$past(enc.last_char)))
		else $error("last character appeared under a stall");

endmodule

// ----- design/b64e_front.sv -----
// front end: collects bytes into groups of three and pushes finished groups
module b64e_front (
	input  logic             clk,
	input  logic             arst_n,
	b64e_in_if.sink          raw,
	input  b64e_pkg::head_t  head,
	output b64e_pkg::push_t  push
);

	logic [7:0] held_q [2];
	logic [1:0] count_q;
	logic       take;
	logic       store;

	assign raw.ready = !head.full;
	assign take      = raw.valid && raw.ready;
	assign store     = !raw.end_of_message && (count_q < 2'd2);

	always_comb begin
		push.valid      = take && !store;
		push.grp.last   = raw.end_of_message;
		push.grp.total  = count_q + 2'd1;
		unique case (count_q)
			2'd0: push.grp.bits = {raw.data_byte, 16'h0000};
			2'd1: push.grp.bits = {held_q[0], raw.data_byte, 8'h00};
			default: push.grp.bits = {held_q[0], held_q[1], raw.data_byte};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (take) begin
			if (store) begin
				count_q <= count_q + 2'd1;
			end else begin
				count_q <= 2'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && store) begin
			held_q[count_q[0]] <= raw.data_byte;
		end
	end

endmodule

// ----- design/b64e_queue.sv -----
// two-entry group queue between front and back
module b64e_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  b64e_pkg::push_t  push,
	input  logic             pop,
	output b64e_pkg::head_t  head
);

	b64e_pkg::group_t mem_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;
	logic             do_push;
	logic             do_pop;

	assign do_push    = push.valid && (cnt_q != 2'd2);
	assign do_pop     = pop && (cnt_q != 2'd0);
	assign head.valid = cnt_q != 2'd0;
	assign head.full  = cnt_q == 2'd2;
	assign head.grp   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push.grp;
		end
	end

endmodule

// ----- design/b64e_back.sv -----
// back end: turns one group into four characters through an output register
module b64e_back (
	input  logic             clk,
	input  logic             arst_n,
	input  b64e_pkg::head_t  head,
	output logic             pop,
	b64e_out_if.source       enc
);

	b64e_pkg::group_t grp_q;
	logic             busy_q;
	logic [1:0]       idx_q;
	logic             valid_q;
	logic [7:0]       char_q;
	logic             last_q;
	logic             load;
	logic             adv;
	logic [5:0]       sextet;
	logic [7:0]       next_char;

	assign load = !valid_q || enc.ready;
	assign adv  = busy_q && load;
	assign pop  = head.valid && (!busy_q || (adv && idx_q == 2'd3));

	always_comb begin
		unique case (idx_q)
			2'd0: sextet = grp_q.bits[23:18];
			2'd1: sextet = grp_q.bits[17:12];
			2'd2: sextet = grp_q.bits[11:6];
			default: sextet = grp_q.bits[5:0];
		endcase
		if (idx_q > grp_q.total) begin
			next_char = b64e_pkg::PadChar;
		end else begin
			next_char = b64e_pkg::sextet_char(sextet);
		end
	end

	assign enc.valid     = valid_q;
	assign enc.out_char  = char_q;
	assign enc.last_char = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			idx_q   <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= busy_q;
			end
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= 2'd0;
			end else if (adv) begin
				idx_q <= idx_q + 2'd1;
				if (idx_q == 2'd3) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			grp_q <= head.grp;
		end
		if (adv) begin
			char_q <= next_char;
			last_q <= grp_q.last && (idx_q == 2'd3);
		end
	end

endmodule
